FILE: hdl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// shared constants and codes for the text console writer
// ----------------------------------------------------------------------------
package tcw_pkg;

  // default screen geometry
  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  // cell contents
  localparam logic [7:0] BLANK_CHAR   = 8'h20;
  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] RESET_ATTR   = 8'h02;

  // action codes
  localparam logic [1:0] ACT_PUT   = 2'd0;
  localparam logic [1:0] ACT_BKSP  = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;
  localparam logic [1:0] ACT_READ  = 2'd3;

  // beat widths
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 32;
  localparam int CURSOR_W    = 11;

endpackage

FILE: hdl/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer
// text console buffer with cursor, scroll, backspace, clear and cell read
// ----------------------------------------------------------------------------
// The screen (COLUMNS x ROWS cells, character in the low byte, attribute in
// the high byte) lives in one simple dual-port ram. Put-character, newline,
// backspace and read beats: the accept cycle does the ram write or issues
// the ram read, and the done state then loads the result register once the
// output register is free. A put that runs off the last cell scrolls: the
// ram is copied up one row at one cell a cycle (a copy state, then a drain
// state for the last copy write), then the bottom row is blanked. Clear
// blanks every cell, one per cycle.
// After reset a clearing pass fills the screen with blanks of attribute 2; no
// input beat is taken during it, while configuration writes are taken at any
// time. The single ram write port is what serializes these passes. A
// finished result waits in an output register so the next input beat can be
// taken while it is still not drained.
// ----------------------------------------------------------------------------
module text_console_writer
  import tcw_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // input beats
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // action[1:0], char_code[9:2], cell_index[20:10]
  // result beats
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // cell_char[7:0], cell_attr[15:8], cursor_index[26:16]
  // text_attribute register write
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [7:0]             cfg_data
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);      // ram address
  localparam int CW    = $clog2(CELLS + 1);  // cursor arithmetic may reach CELLS before a scroll
  localparam int LW    = $clog2(COLUMNS);    // column counter

  // sequencer states
  localparam logic [2:0] S_INIT  = 3'd0;  // clearing pass after reset
  localparam logic [2:0] S_IDLE  = 3'd1;  // waiting for an input beat
  localparam logic [2:0] S_DONE  = 3'd2;  // result ready for the output register
  localparam logic [2:0] S_COPY  = 3'd3;  // scroll, copying rows up
  localparam logic [2:0] S_DRAIN = 3'd4;  // scroll, last copy write
  localparam logic [2:0] S_BLANK = 3'd5;  // blanking a range of cells

  // input beat fields
  logic [1:0]  action;
  logic [7:0]  char_code;
  logic [10:0] cell_index;
  logic [31:0] idx_wide;
  logic        idx_in_range;

  assign action     = s_tdata[1:0];
  assign char_code  = s_tdata[9:2];
  assign cell_index = s_tdata[20:10];
  assign idx_wide   = 32'(cell_index);
  assign idx_in_range = (idx_wide < 32'(CELLS));

  // registers
  logic [2:0]    state;
  logic [7:0]    text_attribute;
  logic [CW-1:0] cursor;
  logic [LW-1:0] column;
  logic [AW-1:0] sweep;
  logic [AW-1:0] rd_addr;
  logic          res_read;     // result carries ram data
  logic          copy_wv;      // copy write pending from last read
  logic [AW-1:0] copy_wa;

  // ram port signals
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [15:0]   ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [15:0]   ram_rdata;

  logic          in_beat;
  logic          out_free;
  logic [CW-1:0] cursor_inc;
  logic [CW-1:0] cursor_dec;
  logic [CW-1:0] cursor_nl;
  logic [LW-1:0] column_inc;
  logic [LW-1:0] column_dec;
  logic [31:0]   cursor_wide;
  logic          put_scroll;   // this put runs off the last cell

  assign s_tready  = (state == S_IDLE);
  assign in_beat   = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;

  // cursor arithmetic, column tracked alongside so no divide is needed
  assign cursor_inc = cursor + CW'(1);
  assign cursor_dec = cursor - CW'(1);
  assign cursor_nl  = cursor + CW'(COLUMNS) - CW'(column);
  assign column_inc = (column == LW'(COLUMNS - 1)) ? '0 : column + LW'(1);
  assign column_dec = (column == '0) ? LW'(COLUMNS - 1) : column - LW'(1);
  assign cursor_wide = 32'(cursor);
  assign put_scroll = (char_code == NEWLINE_CODE) ? (cursor_nl == CW'(CELLS))
                                                  : (cursor_inc == CW'(CELLS));

  // ram write port: pending copy write wins, then the sweeps, then the beat
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = sweep;
    ram_wdata = {text_attribute, BLANK_CHAR};
    if (copy_wv) begin
      ram_we    = 1'b1;
      ram_waddr = copy_wa;
      ram_wdata = ram_rdata;
    end else begin
      case (state)
        S_INIT: begin
          ram_we    = 1'b1;
          ram_wdata = {RESET_ATTR, BLANK_CHAR};
        end
        S_BLANK: begin
          ram_we = 1'b1;
        end
        S_IDLE: begin
          if (in_beat && action == ACT_PUT && char_code != NEWLINE_CODE) begin
            ram_we    = 1'b1;
            ram_waddr = cursor[AW-1:0];
            ram_wdata = {text_attribute, char_code};
          end else if (in_beat && action == ACT_BKSP && cursor != '0) begin
            ram_we    = 1'b1;
            ram_waddr = cursor_dec[AW-1:0];
          end
        end
        default: begin
          ram_we = 1'b0;
        end
      endcase
    end
  end

  // ram read port: the copy source, the beat's cell, or the held cell
  always_comb begin
    case (state)
      S_COPY:  ram_raddr = sweep;
      S_IDLE:  ram_raddr = idx_wide[AW-1:0];
      default: ram_raddr = rd_addr;
    endcase
  end

  tcw_ram #(
    .WIDTH(16),
    .DEPTH(CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      text_attribute <= RESET_ATTR;
    end else if (cfg_valid && cfg_ready) begin
      text_attribute <= cfg_data;
    end
  end

  // sequencer, cursor and sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_INIT;
      cursor   <= '0;
      column   <= '0;
      sweep    <= '0;
      copy_wv  <= 1'b0;
      res_read <= 1'b0;
    end else begin
      copy_wv <= (state == S_COPY);
      copy_wa <= sweep - AW'(COLUMNS);
      case (state)
        S_INIT: begin
          sweep <= sweep + AW'(1);
          if (sweep == AW'(CELLS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_beat) begin
            res_read <= (action == ACT_READ) && idx_in_range;
            rd_addr  <= idx_wide[AW-1:0];
            case (action)
              ACT_PUT: begin
                if (put_scroll) begin
                  // ran off the last cell: scroll, cursor to the bottom row
                  cursor <= CW'(CELLS - COLUMNS);
                  column <= '0;
                  sweep  <= AW'(COLUMNS);
                  state  <= S_COPY;
                end else if (char_code == NEWLINE_CODE) begin
                  cursor <= cursor_nl;
                  column <= '0;
                  state  <= S_DONE;
                end else begin
                  cursor <= cursor_inc;
                  column <= column_inc;
                  state  <= S_DONE;
                end
              end
              ACT_BKSP: begin
                if (cursor != '0) begin
                  cursor <= cursor_dec;
                  column <= column_dec;
                end
                state <= S_DONE;
              end
              ACT_CLEAR: begin
                cursor <= '0;
                column <= '0;
                sweep  <= '0;
                state  <= S_BLANK;
              end
              ACT_READ: begin
                state <= S_DONE;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_COPY: begin
          sweep <= sweep + AW'(1);
          if (sweep == AW'(CELLS - 1)) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          sweep <= AW'(CELLS - COLUMNS);
          state <= S_BLANK;
        end
        S_BLANK: begin
          sweep <= sweep + AW'(1);
          if (sweep == AW'(CELLS - 1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output register, loaded once the previous result has gone
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      m_tdata[15:0]  <= res_read ? ram_rdata : 16'h0000;
      m_tdata[26:16] <= cursor_wide[CURSOR_W-1:0];
      m_tdata[31:27] <= '0;
    end
  end

endmodule

FILE: hdl/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram
// simple dual-port ram, one write port, one read port with registered data
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/tcw_checker.sv
// ----------------------------------------------------------------------------
// tcw_checker
// port-level checks for the text console writer, bound to the top level
// ----------------------------------------------------------------------------
module tcw_checker
  import tcw_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata
);

  localparam int CELLS = COLUMNS * ROWS;

  logic       in_beat;
  logic       out_beat;
  logic [2:0] pending;   // beats taken but not yet delivered
  logic [31:0] cur_wide;

  assign in_beat  = s_tvalid && s_tready;
  assign out_beat = m_tvalid && m_tready;
  assign cur_wide = 32'(m_tdata[26:16]);

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 3'(in_beat) - 3'(out_beat);
    end
  end

  // one item at a time: no second beat right after a taken one
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_beat |=> !s_tready)
    else $error("input taken in the cycle after a beat");

  // a result never appears without an item behind it
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> pending != 3'd0)
    else $error("result without an accepted item");

  // at most one item in work and one result waiting
  a_bounded: assert property (@(posedge clk) disable iff (rst)
    pending <= 3'd2)
    else $error("too many items outstanding");

  // reported cursor stays on the screen (checked only for screens of up to 2048 cells)
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (CELLS > 2048 || cur_wide < 32'(CELLS)))
    else $error("cursor off the screen");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

endmodule

bind text_console_writer tcw_checker #(
  .COLUMNS(COLUMNS),
  .ROWS   (ROWS)
) u_tcw_checker (.*);
